// ===== rtl/core/sisi_pkg.sv =====
// ---------------------------------------------------------------------------
// sisi_pkg: shared types and constants of the sorted interval set
// Field widths, operation and status codes, cell commands and the cell hit
// flags that travel from the cell row to the top-level decision logic.
// ---------------------------------------------------------------------------
package sisi_pkg;

    // Transaction field widths
    localparam int OP_W     = 2;
    localparam int ROW_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    // Parameter defaults
    localparam int MAX_INTERVALS_DEF = 64;
    localparam int ROW_BITS_DEF      = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NEW      = 3'd0,
        STAT_COVERED  = 3'd1,
        STAT_EXTENDED = 3'd2,
        STAT_MERGED   = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_READ_OK  = 3'd5,
        STAT_BAD_SLOT = 3'd6,
        STAT_CLEARED  = 3'd7
    } status_t;

    // Update broadcast to every cell on the commit cycle
    typedef enum logic [2:0] {
        CMD_HOLD      = 3'd0,
        CMD_NEW       = 3'd1,
        CMD_MERGE     = 3'd2,
        CMD_EXT_LEFT  = 3'd3,
        CMD_EXT_RIGHT = 3'd4
    } cell_cmd_t;

    // Per-cell findings about the row under test
    typedef struct packed {
        logic covered;
        logic left_adj;
        logic right_adj;
    } cell_hit_t;

endpackage

// ===== rtl/core/sisi_req_if.sv =====
// ---------------------------------------------------------------------------
// sisi_req_if: request channel of the sorted interval set
// Valid/ready handshake carrying operation, row and slot.
// ---------------------------------------------------------------------------
interface sisi_req_if
    import sisi_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output operation, output row, output slot, input ready);
    modport sink   (input valid, input operation, input row, input slot, output ready);
endinterface

// ===== rtl/core/sisi_rsp_if.sv =====
// ---------------------------------------------------------------------------
// sisi_rsp_if: response channel of the sorted interval set
// Valid/ready handshake carrying status, interval bounds and interval count.
// ---------------------------------------------------------------------------
interface sisi_rsp_if
    import sisi_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ROW_W-1:0]    first_row;
    logic [ROW_W-1:0]    last_row;
    logic [TOTAL_W-1:0]  interval_total;

    modport source (output valid, output status, output first_row, output last_row,
                    output interval_total, input ready);
    modport sink   (input valid, input status, input first_row, input last_row,
                    input interval_total, output ready);
endinterface

// ===== rtl/core/sorted_interval_set_insert_top.sv =====
// ---------------------------------------------------------------------------
// sorted_interval_set_insert_top: sorted interval set with insert and merge
// Keeps occupied rows as an ascending list of disjoint, non-adjacent
// intervals held in a row of cells; inserts, reads and clears.
//
//   Channel | Dir | Fields                                       | Handshake
//   --------+-----+----------------------------------------------+----------
//   req     | in  | operation, row, slot                         | valid/ready
//   rsp     | out | status, first_row, last_row, interval_total  | valid/ready
//
// The take cycle latches compare flags in all cells, and the commit cycle
// decides from those flags and shifts the cells in parallel, independent
// of list length.
// Reset clears the interval count and handshake state; cell contents are
// left as they are and are never read before they are written.
// A stalled response holds the commit; req is taken again once it commits.
// ---------------------------------------------------------------------------
module sorted_interval_set_insert_top
    import sisi_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int ROW_BITS      = ROW_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    sisi_req_if.sink      req,
    sisi_rsp_if.source    rsp
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int SELW  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    op_t                 op_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [SLOT_W-1:0]   slot_reg;

    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [ROW_W-1:0]    first_reg, first_next;
    logic [ROW_W-1:0]    last_reg, last_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    logic                take, commit;
    logic [ROW_BITS-1:0] in_row;
    cell_cmd_t           cmd;

    logic                ge_w [MAX_INTERVALS];
    logic [ROW_BITS-1:0] lo_w [MAX_INTERVALS];
    logic [ROW_BITS-1:0] hi_w [MAX_INTERVALS];
    logic [ROW_BITS-1:0] rlo_w [MAX_INTERVALS];
    logic [ROW_BITS-1:0] rhi_w [MAX_INTERVALS];
    cell_hit_t           hit_w [MAX_INTERVALS];

    cell_hit_t           hit_any;
    logic [ROW_BITS-1:0] rd_lo_any, rd_hi_any;

    assign in_row    = ROW_BITS'(req.row);
    assign take      = req.valid && req.ready;
    assign commit    = (state_reg == S_BUSY) && (!out_valid_reg || rsp.ready);
    assign req.ready = (state_reg == S_IDLE);

    // Cell row
    for (genvar k = 0; k < MAX_INTERVALS; k++)
    begin : g_cell
        logic                prev_ge, next_ge;
        logic [ROW_BITS-1:0] prev_lo, prev_hi, next_lo, next_hi;

        if (k == 0)
        begin : g_first
            assign prev_ge = 1'b0;
            assign prev_lo = row_reg;
            assign prev_hi = row_reg;
        end
        else
        begin : g_mid_lo
            assign prev_ge = ge_w[k-1];
            assign prev_lo = lo_w[k-1];
            assign prev_hi = hi_w[k-1];
        end

        if (k == MAX_INTERVALS - 1)
        begin : g_last
            assign next_ge = 1'b1;
            assign next_lo = lo_w[k];
            assign next_hi = hi_w[k];
        end
        else
        begin : g_mid_hi
            assign next_ge = ge_w[k+1];
            assign next_lo = lo_w[k+1];
            assign next_hi = hi_w[k+1];
        end

        sisi_cell #(
            .MAX_INTERVALS (MAX_INTERVALS),
            .ROW_BITS      (ROW_BITS),
            .INDEX         (k)
        ) u_cell (
            .clk     (clk),
            .cmp_en  (take),
            .count   (count_reg),
            .cmp_row (in_row),
            .wr_row  (row_reg),
            .slot    (slot_reg),
            .cmd     (cmd),
            .prev_ge (prev_ge),
            .next_ge (next_ge),
            .prev_lo (prev_lo),
            .prev_hi (prev_hi),
            .next_lo (next_lo),
            .next_hi (next_hi),
            .ge      (ge_w[k]),
            .lo      (lo_w[k]),
            .hi      (hi_w[k]),
            .hit     (hit_w[k]),
            .rd_lo   (rlo_w[k]),
            .rd_hi   (rhi_w[k])
        );
    end

    // Gather cell findings and read data
    always_comb
    begin
        hit_any   = '0;
        rd_lo_any = '0;
        rd_hi_any = '0;
        for (int k = 0; k < MAX_INTERVALS; k++)
        begin
            hit_any   = hit_any | hit_w[k];
            rd_lo_any = rd_lo_any | rlo_w[k];
            rd_hi_any = rd_hi_any | rhi_w[k];
        end
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= op_t'(req.operation);
            row_reg  <= in_row;
            slot_reg <= req.slot;
        end
    end

    // Decide the operation outcome
    always_comb
    begin
        cmd         = CMD_HOLD;
        count_next  = count_reg;
        status_next = STAT_BAD_SLOT;
        first_next  = '0;
        last_next   = '0;
        unique case (op_reg)
            OP_INSERT:
            begin
                priority if (hit_any.covered)
                begin
                    status_next = STAT_COVERED;
                end
                else if (hit_any.left_adj && hit_any.right_adj)
                begin
                    cmd         = CMD_MERGE;
                    status_next = STAT_MERGED;
                    count_next  = count_reg - CNT_W'(1);
                end
                else if (hit_any.left_adj)
                begin
                    cmd         = CMD_EXT_LEFT;
                    status_next = STAT_EXTENDED;
                end
                else if (hit_any.right_adj)
                begin
                    cmd         = CMD_EXT_RIGHT;
                    status_next = STAT_EXTENDED;
                end
                else if (count_reg == CNT_W'(MAX_INTERVALS))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    cmd         = CMD_NEW;
                    status_next = STAT_NEW;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (SELW'(slot_reg) < SELW'(count_reg))
                begin
                    status_next = STAT_READ_OK;
                    first_next  = ROW_W'(rd_lo_any);
                    last_next   = ROW_W'(rd_hi_any);
                end
            end
            OP_CLEAR:
            begin
                status_next = STAT_CLEARED;
                count_next  = '0;
            end
            default:
            begin
                status_next = STAT_BAD_SLOT;
            end
        endcase
        if (!commit)
        begin
            cmd        = CMD_HOLD;
            count_next = count_reg;
        end
        total_next = TOTAL_W'(count_next);
    end

    // Advance the sequencer and the response valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the response payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= status_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            total_reg  <= total_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.first_row      = first_reg;
    assign rsp.last_row       = last_reg;
    assign rsp.interval_total = total_reg;

endmodule

// ===== rtl/core/sisi_cell.sv =====
// ---------------------------------------------------------------------------
// sisi_cell: one slot of the interval list
// Holds one interval, compares it with the incoming row when a transaction
// is taken, and on commit loads its own value, a neighbor's or the row.
// ---------------------------------------------------------------------------
module sisi_cell
    import sisi_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int ROW_BITS      = ROW_BITS_DEF,
    parameter int INDEX         = 0
)
(
    input  logic                                  clk,
    input  logic                                  cmp_en,
    input  logic [$clog2(MAX_INTERVALS+1)-1:0]    count,
    input  logic [ROW_BITS-1:0]                   cmp_row,
    input  logic [ROW_BITS-1:0]                   wr_row,
    input  logic [SLOT_W-1:0]                     slot,
    input  cell_cmd_t                             cmd,
    input  logic                                  prev_ge,
    input  logic                                  next_ge,
    input  logic [ROW_BITS-1:0]                   prev_lo,
    input  logic [ROW_BITS-1:0]                   prev_hi,
    input  logic [ROW_BITS-1:0]                   next_lo,
    input  logic [ROW_BITS-1:0]                   next_hi,
    output logic                                  ge,
    output logic [ROW_BITS-1:0]                   lo,
    output logic [ROW_BITS-1:0]                   hi,
    output cell_hit_t                             hit,
    output logic [ROW_BITS-1:0]                   rd_lo,
    output logic [ROW_BITS-1:0]                   rd_hi
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int SELW  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(INDEX);
    localparam logic [SELW-1:0]  IDX_SEL = SELW'(INDEX);

    logic [ROW_BITS-1:0] lo_reg, lo_next;
    logic [ROW_BITS-1:0] hi_reg, hi_next;
    logic                ge_reg, le_reg, ep1_reg, sp1_reg;
    logic                cell_valid;
    logic                at_i, at_im1, rd_sel;

    assign cell_valid = (IDX_CNT < count);

    // Latch comparison flags against the incoming row
    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            ge_reg  <= !(cell_valid && (hi_reg < cmp_row));
            le_reg  <= (lo_reg <= cmp_row);
            ep1_reg <= (({1'b0, hi_reg} + (ROW_BITS+1)'(1)) == {1'b0, cmp_row});
            sp1_reg <= ({1'b0, lo_reg} == ({1'b0, cmp_row} + (ROW_BITS+1)'(1)));
        end
    end

    // Locate this cell relative to the insertion point
    assign at_i   = ge_reg && !prev_ge;
    assign at_im1 = !ge_reg && next_ge;

    assign hit.covered   = at_i && cell_valid && le_reg;
    assign hit.right_adj = at_i && cell_valid && sp1_reg;
    assign hit.left_adj  = at_im1 && ep1_reg;

    // Offer contents for a read
    assign rd_sel = (SELW'(slot) == IDX_SEL);
    assign rd_lo  = rd_sel ? lo_reg : '0;
    assign rd_hi  = rd_sel ? hi_reg : '0;

    // Load own, neighbor or row value on commit
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        unique case (cmd)
            CMD_NEW:
            begin
                if (at_i)
                begin
                    lo_next = wr_row;
                    hi_next = wr_row;
                end
                else if (ge_reg)
                begin
                    lo_next = prev_lo;
                    hi_next = prev_hi;
                end
            end
            CMD_MERGE:
            begin
                if (at_im1)
                begin
                    hi_next = next_hi;
                end
                else if (ge_reg)
                begin
                    lo_next = next_lo;
                    hi_next = next_hi;
                end
            end
            CMD_EXT_LEFT:
            begin
                if (at_im1)
                begin
                    hi_next = wr_row;
                end
            end
            CMD_EXT_RIGHT:
            begin
                if (at_i)
                begin
                    lo_next = wr_row;
                end
            end
            default:
            begin
                lo_next = lo_reg;
                hi_next = hi_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign ge = ge_reg;
    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

// ===== bench/tb_sorted_interval_set_insert_top.sv =====
// ---------------------------------------------------------------------------
// tb_sorted_interval_set_insert_top: self-checking bench for the interval set
// Drives insert, read, clear and unused-code transactions through the request
// channel and compares every response with a software copy of the interval
// list. Directed cases cover the range ends, extend, merge, covered rows and
// bad slots. Random episodes grow dense row clusters and fill the list past
// capacity to reach the full case. Both channels stall at random.
// ---------------------------------------------------------------------------
module tb_sorted_interval_set_insert_top
    import sisi_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPAN_DEPTH   = MAX_INTERVALS_DEF;
    localparam int RANDOM_ITEMS = 580;
    localparam int FILL_ROWS    = 70;
    localparam int HOLD_CYCLES  = 90;

    typedef struct {
        status_t            status;
        logic [ROW_W-1:0]   first_row;
        logic [ROW_W-1:0]   last_row;
        logic [TOTAL_W-1:0] interval_total;
    } set_result_t;

    // Track the interval list and the responses it implies
    class interval_set_scoreboard;
        logic [ROW_W-1:0] span_start [SPAN_DEPTH];
        logic [ROW_W-1:0] span_end [SPAN_DEPTH];
        int unsigned      span_count;
        set_result_t      pending_results [$];
        int unsigned      failures;

        function new();
            span_count = 0;
            failures   = 0;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Apply one insert to the list and return its status
        function status_t insert_row(logic [ROW_W-1:0] row);
            int unsigned idx;
            int unsigned k;
            bit          joins_lower;
            bit          joins_upper;
            idx = 0;
            while (idx < span_count && span_end[idx] < row)
                idx++;
            if (idx < span_count && span_start[idx] <= row)
                return STAT_COVERED;
            joins_lower = (idx > 0) &&
                          ({1'b0, span_end[idx-1]} + 17'd1 == {1'b0, row});
            joins_upper = (idx < span_count) &&
                          ({1'b0, span_start[idx]} == {1'b0, row} + 17'd1);
            if (joins_lower && joins_upper)
            begin
                span_end[idx-1] = span_end[idx];
                for (k = idx; k + 1 < span_count; k++)
                begin
                    span_start[k] = span_start[k+1];
                    span_end[k]   = span_end[k+1];
                end
                span_count--;
                return STAT_MERGED;
            end
            if (joins_lower)
            begin
                span_end[idx-1] = row;
                return STAT_EXTENDED;
            end
            if (joins_upper)
            begin
                span_start[idx] = row;
                return STAT_EXTENDED;
            end
            if (span_count >= SPAN_DEPTH)
                return STAT_FULL;
            for (k = span_count; k > idx; k--)
            begin
                span_start[k] = span_start[k-1];
                span_end[k]   = span_end[k-1];
            end
            span_start[idx] = row;
            span_end[idx]   = row;
            span_count++;
            return STAT_NEW;
        endfunction

        // Note an accepted request and queue the response it must produce
        function void note_request(op_t op, logic [ROW_W-1:0] row,
                                   logic [SLOT_W-1:0] slot);
            set_result_t res;
            res.first_row = '0;
            res.last_row  = '0;
            case (op)
                OP_INSERT: res.status = insert_row(row);
                OP_READ:
                begin
                    if (slot < span_count)
                    begin
                        res.status    = STAT_READ_OK;
                        res.first_row = span_start[slot];
                        res.last_row  = span_end[slot];
                    end
                    else
                        res.status = STAT_BAD_SLOT;
                end
                OP_CLEAR:
                begin
                    span_count = 0;
                    res.status = STAT_CLEARED;
                end
                default: res.status = STAT_BAD_SLOT;
            endcase
            res.interval_total = TOTAL_W'(span_count);
            pending_results.insert(pending_results.size(), res);
        endfunction

        // Compare one accepted response with the oldest expectation
        function void check_response(logic [STATUS_W-1:0] status,
                                     logic [ROW_W-1:0] first_row,
                                     logic [ROW_W-1:0] last_row,
                                     logic [TOTAL_W-1:0] interval_total);
            set_result_t exp;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected response: status %0d first %0d last %0d total %0d",
                             status, first_row, last_row, interval_total);
                return;
            end
            exp = pending_results.pop_front();
            if (status !== exp.status || first_row !== exp.first_row ||
                last_row !== exp.last_row || interval_total !== exp.interval_total)
            begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: expected status %0d first %0d last %0d total %0d, ",
                              "got %0d %0d %0d %0d"},
                             exp.status, exp.first_row, exp.last_row, exp.interval_total,
                             status, first_row, last_row, interval_total);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sisi_req_if req_ch ();
    sisi_rsp_if rsp_ch ();

    interval_set_scoreboard board = new();

    int unsigned sent_total;
    int unsigned fill_runs;

    sorted_interval_set_insert_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one transaction, idling first at random, and hold it until taken
    task automatic send_request(op_t op, logic [ROW_W-1:0] row, logic [SLOT_W-1:0] slot);
        bit calm;
        calm = (sent_total >= 300 && sent_total < 400);
        if (!calm && $urandom_range(0, 99) < 18)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.row       <= row;
        req_ch.slot      <= slot;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        board.note_request(op, row, slot);
        sent_total++;
    endtask

    // Read a slot, mostly one that is held or just past the end
    task automatic random_read();
        int unsigned top;
        top = (board.span_count > 63) ? 63 : board.span_count;
        if (board.span_count > 0 && $urandom_range(0, 99) < 70)
            send_request(OP_READ, ROW_W'($urandom), SLOT_W'($urandom_range(0, top)));
        else
            send_request(OP_READ, ROW_W'($urandom), SLOT_W'($urandom));
    endtask

    task automatic run_directed();
        send_request(OP_READ, '0, '0);
        send_request(OP_INSERT, 16'd0, '1);
        send_request(OP_INSERT, 16'hFFFF, '0);
        send_request(OP_INSERT, 16'd1, '0);
        send_request(OP_INSERT, 16'hFFFE, '0);
        send_request(OP_INSERT, 16'd0, '0);
        send_request(OP_INSERT, 16'hFFFF, '0);
        send_request(OP_INSERT, 16'd3, '0);
        send_request(OP_INSERT, 16'd2, '0);
        send_request(OP_INSERT, 16'd100, '0);
        send_request(OP_INSERT, 16'd99, '0);
        send_request(OP_READ, '1, 6'd0);
        send_request(OP_READ, '0, 6'd1);
        send_request(OP_READ, '0, 6'd2);
        send_request(OP_READ, '0, 6'd3);
        send_request(OP_READ, '0, 6'd63);
        send_request(OP_UNUSED, 16'hFFFF, 6'd63);
        send_request(OP_UNUSED, 16'h0000, 6'd0);
        send_request(OP_CLEAR, 16'h5555, 6'd21);
        send_request(OP_READ, '0, 6'd0);
        send_request(OP_INSERT, 16'h8000, 6'd42);
        send_request(OP_READ, 16'hAAAA, 6'd0);
        send_request(OP_CLEAR, '0, '0);
    endtask

    // Grow clusters of rows in a narrow window: extends, merges, covers
    task automatic dense_episode();
        int unsigned window;
        int unsigned base;
        int unsigned n;
        int unsigned pick;
        window = $urandom_range(8, 120);
        base   = $urandom_range(0, 65535 - window);
        n      = $urandom_range(20, 50);
        send_request(OP_CLEAR, ROW_W'($urandom), SLOT_W'($urandom));
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_request(OP_INSERT, ROW_W'(base + $urandom_range(0, window)),
                             SLOT_W'($urandom));
            else if (pick < 92)
                random_read();
            else if (pick < 96)
                send_request(OP_UNUSED, ROW_W'($urandom), SLOT_W'($urandom));
            else
                send_request(OP_INSERT, ROW_W'($urandom), SLOT_W'($urandom));
        end
    endtask

    // Insert spaced rows past capacity, then probe the full list
    task automatic fill_episode();
        int order [FILL_ROWS];
        int j;
        int tmp;
        int base;
        int r;
        case (fill_runs % 3)
            0: base = 0;
            1: base = 65535 - 2 * (FILL_ROWS - 1);
            default: base = $urandom_range(1, 65000);
        endcase
        fill_runs++;
        send_request(OP_CLEAR, ROW_W'($urandom), SLOT_W'($urandom));
        for (j = 0; j < FILL_ROWS; j++)
            order[j] = j;
        for (j = FILL_ROWS - 1; j > 0; j--)
        begin
            r        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[r];
            order[r] = tmp;
        end
        for (j = 0; j < FILL_ROWS; j++)
        begin
            if ($urandom_range(0, 99) < 15)
                random_read();
            send_request(OP_INSERT, ROW_W'(base + 2 * order[j]), SLOT_W'($urandom));
        end
        repeat (12)
        begin
            r = base - 1 + int'($urandom_range(0, 2 * FILL_ROWS + 1));
            if (r < 0)
                r = 0;
            if (r > 65535)
                r = 65535;
            send_request(OP_INSERT, ROW_W'(r), SLOT_W'($urandom));
            if ($urandom_range(0, 99) < 30)
                random_read();
        end
    endtask

    task automatic run_random();
        int unsigned stop_at;
        stop_at = sent_total + RANDOM_ITEMS;
        while (sent_total < stop_at)
        begin
            if ($urandom_range(0, 99) < 30)
                fill_episode();
            else
                dense_episode();
        end
    endtask

    // Main sequence: reset, directed, random, drain
    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.row       = '0;
        req_ch.slot      = '0;
        sent_total       = 0;
        fill_runs        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (board.failures == 0 && board.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Accept responses; stall at random and hold off for long stretches
    initial
    begin
        int unsigned got;
        int unsigned hold_left;
        int unsigned next_hold_at;
        bit          calm;
        got          = 0;
        hold_left    = 0;
        next_hold_at = 100;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                board.check_response(rsp_ch.status, rsp_ch.first_row, rsp_ch.last_row,
                                     rsp_ch.interval_total);
                got++;
            end
            calm = (got >= 150 && got < 260);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (got >= next_hold_at)
            begin
                hold_left     = HOLD_CYCLES;
                next_hold_at += 400;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
        end
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
